FILE: src/rti_pkg.sv
// Shared types and constants of the ray/triangle intersection block.
package rti_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VW        = 32;
	localparam int EW        = VW + 1;
	localparam int PW        = 2 * EW;
	localparam int XW        = PW + 1;
	localparam int LO_W      = 34;
	localparam int HI_W      = XW - LO_W;
	localparam int SW        = 104;
	localparam int RW        = SW + 32;
	localparam int DIST_W    = 31;
	localparam int NPROD     = 12;
	localparam int QDEPTH    = 4;
	localparam int QAW       = 2;
	localparam int CFG_AW    = 8;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [CFG_AW-1:0] {
		REG_ORIGIN_X = 8'd0,
		REG_ORIGIN_Y = 8'd1,
		REG_ORIGIN_Z = 8'd2,
		REG_DIR_X    = 8'd3,
		REG_DIR_Y    = 8'd4,
		REG_DIR_Z    = 8'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VW-1:0] va_x, va_y, va_z;
		logic signed [VW-1:0] vb_x, vb_y, vb_z;
		logic signed [VW-1:0] vc_x, vc_y, vc_z;
	} tri_t;

	typedef struct packed {
		logic signed [VW-1:0] ox, oy, oz;
		logic signed [VW-1:0] dx, dy, dz;
	} ray_t;

	typedef struct packed {
		logic signed [EW-1:0] e1x, e1y, e1z;
		logic signed [EW-1:0] e2x, e2y, e2z;
		logic signed [EW-1:0] sx, sy, sz;
	} edges_t;

	typedef struct packed {
		logic           full;
		logic           empty;
		logic [QAW:0]   count;
	} qstat_t;

endpackage

FILE: src/rti_if.sv
// Handshake channels of the ray/triangle intersection block.
interface rti_tri_if;
	logic valid;
	logic ready;
	logic signed [31:0] va_x, va_y, va_z;
	logic signed [31:0] vb_x, vb_y, vb_z;
	logic signed [31:0] vc_x, vc_y, vc_z;
	modport source(output valid, va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z,
		input ready);
	modport sink(input valid, va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z,
		output ready);
endinterface

interface rti_res_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [30:0] distance;
	modport source(output valid, hit, distance, input ready);
	modport sink(input valid, hit, distance, output ready);
endinterface

interface rti_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/rti_front.sv
// Front end: takes triangle beats and forms edge and offset vectors.
module rti_front (
	rti_tri_if.sink          triangle,
	input  rti_pkg::ray_t    ray,
	input  rti_pkg::qstat_t  qstat,
	output logic             push,
	output rti_pkg::edges_t  edges
);
	import rti_pkg::*;

	tri_t t;

	always_comb begin
		t.va_x = triangle.va_x;
		t.va_y = triangle.va_y;
		t.va_z = triangle.va_z;
		t.vb_x = triangle.vb_x;
		t.vb_y = triangle.vb_y;
		t.vb_z = triangle.vb_z;
		t.vc_x = triangle.vc_x;
		t.vc_y = triangle.vc_y;
		t.vc_z = triangle.vc_z;
		edges.e1x = EW'(t.va_x) - EW'(t.vb_x);
		edges.e1y = EW'(t.va_y) - EW'(t.vb_y);
		edges.e1z = EW'(t.va_z) - EW'(t.vb_z);
		edges.e2x = EW'(t.va_x) - EW'(t.vc_x);
		edges.e2y = EW'(t.va_y) - EW'(t.vc_y);
		edges.e2z = EW'(t.va_z) - EW'(t.vc_z);
		edges.sx  = EW'(t.va_x) - EW'(ray.ox);
		edges.sy  = EW'(t.va_y) - EW'(ray.oy);
		edges.sz  = EW'(t.va_z) - EW'(ray.oz);
	end

	assign triangle.ready = !qstat.full;
	assign push           = triangle.valid && !qstat.full;

endmodule

FILE: src/rti_queue.sv
// Short queue between front and back ends.
module rti_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rti_pkg::edges_t  wdata,
	input  logic             pop,
	output rti_pkg::edges_t  rdata,
	output rti_pkg::qstat_t  qstat
);
	import rti_pkg::*;

	edges_t         mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign rdata       = mem_q[rptr_q];
	assign qstat.count = count_q;
	assign qstat.full  = count_q == (QAW+1)'(QDEPTH);
	assign qstat.empty = count_q == '0;

endmodule

FILE: src/rti_div.sv
// Pipelined restoring divider giving a saturated 31-bit quotient.
module rti_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_vld,
	input  logic                      in_hit,
	input  logic [rti_pkg::SW-1:0]    num,
	input  logic [rti_pkg::SW-1:0]    den,
	output logic                      out_vld,
	output logic                      out_hit,
	output logic [rti_pkg::DIST_W-1:0] quot
);
	import rti_pkg::*;

	localparam int NST = DIST_W + 1;

	logic              vld_q [NST];
	logic              hit_s [NST];
	logic              sat_s [NST];
	logic [RW-1:0]     rem_s [NST];
	logic [RW-1:0]     den_s [NST];
	logic [DIST_W-1:0] q_s   [NST];

	logic [RW-1:0] n0;
	assign n0 = in_hit ? (RW'(num) << FRAC_BITS) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_vld;
			for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s[0] <= in_hit;
			sat_s[0] <= in_hit && (n0 >= (RW'(den) << DIST_W));
			rem_s[0] <= n0;
			den_s[0] <= RW'(den);
			q_s[0]   <= '0;
		end
	end

	for (genvar i = 1; i < NST; i++) begin : g_step
		localparam int K = DIST_W - i;
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = den_s[i-1] << K;
		assign ge  = rem_s[i-1] >= dsh;
		always_ff @(posedge clk) begin
			if (adv) begin
				hit_s[i] <= hit_s[i-1];
				sat_s[i] <= sat_s[i-1];
				den_s[i] <= den_s[i-1];
				rem_s[i] <= ge ? rem_s[i-1] - dsh : rem_s[i-1];
				q_s[i]   <= q_s[i-1] | (DIST_W'(ge) << K);
			end
		end
	end

	// a miss may carry a zero divisor, so its quotient is forced to zero
	assign out_vld = vld_q[NST-1];
	assign out_hit = hit_s[NST-1];
	assign quot    = !hit_s[NST-1] ? '0 : sat_s[NST-1] ? DIST_MAX : q_s[NST-1];

endmodule

FILE: src/rti_back.sv
// Back end: determinant, numerators, hit tests and distance.
module rti_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rti_pkg::ray_t    ray,
	input  rti_pkg::edges_t  edges,
	input  rti_pkg::qstat_t  qstat,
	output logic             pop,
	rti_res_if.source        result
);
	import rti_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [EW-1:0] rx, ry, rz;
	assign rx = EW'(ray.dx);
	assign ry = EW'(ray.dy);
	assign rz = EW'(ray.dz);

	edges_t e_s1, e_s2;
	logic signed [PW-1:0] p_s1 [NPROD];
	logic signed [XW-1:0] m_s2 [3];
	logic signed [XW-1:0] n_s2 [3];

	logic signed [EW-1:0] opa [NPROD];
	logic signed [XW-1:0] opb [NPROD];
	logic signed [EW+LO_W+1-1:0] lo_s3 [NPROD];
	logic signed [EW+HI_W-1:0]   hi_s3 [NPROD];
	logic signed [SW-1:0] f_s4 [NPROD];

	logic signed [SW-1:0] det_s5, nt_s5, ng_s5, nb_s5;
	logic signed [SW-1:0] det_s6, nt_s6, ng_s6, nb_s6;
	logic                 dz_s6;
	logic [SW-1:0]        det_s7, nt_s7;
	logic                 hit_s7;

	logic signed [SW-1:0] t1, t2;

	logic              d_vld, d_hit;
	logic [DIST_W-1:0] d_q;
	logic              res_vld_q, res_hit_q;
	logic [DIST_W-1:0] res_dist_q;

	assign adv = !res_vld_q || result.ready;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= !qstat.empty;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			res_vld_q <= d_vld;
		end
	end

	// cofactor products
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1     <= edges;
			p_s1[0]  <= edges.e2y * rz;
			p_s1[1]  <= ry * edges.e2z;
			p_s1[2]  <= rx * edges.e2z;
			p_s1[3]  <= edges.e2x * rz;
			p_s1[4]  <= edges.e2x * ry;
			p_s1[5]  <= edges.e2y * rx;
			p_s1[6]  <= edges.e1x * edges.sy;
			p_s1[7]  <= edges.sx * edges.e1y;
			p_s1[8]  <= edges.sx * edges.e1z;
			p_s1[9]  <= edges.e1x * edges.sz;
			p_s1[10] <= edges.e1y * edges.sz;
			p_s1[11] <= edges.sy * edges.e1z;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s2    <= e_s1;
			m_s2[0] <= XW'(p_s1[0]) - XW'(p_s1[1]);
			m_s2[1] <= XW'(p_s1[2]) - XW'(p_s1[3]);
			m_s2[2] <= XW'(p_s1[4]) - XW'(p_s1[5]);
			n_s2[0] <= XW'(p_s1[6]) - XW'(p_s1[7]);
			n_s2[1] <= XW'(p_s1[8]) - XW'(p_s1[9]);
			n_s2[2] <= XW'(p_s1[10]) - XW'(p_s1[11]);
		end
	end

	// det, nt, ng, nb terms; wide operand split in two halves
	always_comb begin
		opa[0]  = e_s2.e1x; opb[0]  = m_s2[0];
		opa[1]  = e_s2.e1y; opb[1]  = m_s2[1];
		opa[2]  = e_s2.e1z; opb[2]  = m_s2[2];
		opa[3]  = e_s2.e2z; opb[3]  = n_s2[0];
		opa[4]  = e_s2.e2y; opb[4]  = n_s2[1];
		opa[5]  = e_s2.e2x; opb[5]  = n_s2[2];
		opa[6]  = rz;       opb[6]  = n_s2[0];
		opa[7]  = ry;       opb[7]  = n_s2[1];
		opa[8]  = rx;       opb[8]  = n_s2[2];
		opa[9]  = e_s2.sx;  opb[9]  = m_s2[0];
		opa[10] = e_s2.sy;  opb[10] = m_s2[1];
		opa[11] = e_s2.sz;  opb[11] = m_s2[2];
	end

	for (genvar j = 0; j < NPROD; j++) begin : g_prod
		always_ff @(posedge clk) begin
			if (adv) begin
				lo_s3[j] <= opa[j] * $signed({1'b0, opb[j][LO_W-1:0]});
				hi_s3[j] <= opa[j] * $signed(opb[j][XW-1:LO_W]);
				f_s4[j]  <= (SW'(hi_s3[j]) <<< LO_W) + SW'(lo_s3[j]);
			end
		end
	end

	assign t1 = det_s6 - ng_s6;
	assign t2 = det_s6 - nb_s6 - ng_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5 <= f_s4[0] + f_s4[1] + f_s4[2];
			nt_s5  <= -(f_s4[3] + f_s4[4] + f_s4[5]);
			ng_s5  <= f_s4[6] + f_s4[7] + f_s4[8];
			nb_s5  <= f_s4[9] + f_s4[10] + f_s4[11];

			dz_s6  <= det_s5 == '0;
			det_s6 <= det_s5[SW-1] ? -det_s5 : det_s5;
			nt_s6  <= det_s5[SW-1] ? -nt_s5 : nt_s5;
			ng_s6  <= det_s5[SW-1] ? -ng_s5 : ng_s5;
			nb_s6  <= det_s5[SW-1] ? -nb_s5 : nb_s5;

			hit_s7 <= !dz_s6 && !nt_s6[SW-1] && !ng_s6[SW-1] && !t1[SW-1] &&
				!nb_s6[SW-1] && !t2[SW-1];
			det_s7 <= det_s6;
			nt_s7  <= nt_s6;
		end
	end

	rti_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (v_s7),
		.in_hit  (hit_s7),
		.num     (nt_s7),
		.den     (det_s7),
		.out_vld (d_vld),
		.out_hit (d_hit),
		.quot    (d_q)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_hit_q  <= d_hit;
			res_dist_q <= d_q;
		end
	end

	assign result.valid    = res_vld_q;
	assign result.hit      = res_hit_q;
	assign result.distance = res_dist_q;

endmodule

FILE: src/ray_triangle_intersect.sv
// Top level of the ray/triangle intersection block.
// Tests a stream of triangles against one ray held in six registers (origin and
// direction, signed Q16.16, written over the cfg channel; the user must write them
// only while idle, which the block does not enforce). Each triangle beat gives one
// result beat: hit, and the distance t in unsigned Q15.16, saturated at 2^31-1 and
// zero on a miss. One triangle is taken per cycle while the queue is not full; the
// datapath is fully pipelined, so results arrive in order, the bulk of it being the
// one-bit-per-stage divider. A four-entry queue parts the edge-forming front end
// from the arithmetic back end; a stalled result freezes the back end only.
module ray_triangle_intersect (
	input  logic      clk,
	input  logic      arst_n,
	rti_cfg_if.sink   cfg,
	rti_tri_if.sink   triangle,
	rti_res_if.source result
);
	import rti_pkg::*;

	ray_t   ray_q;
	edges_t q_wdata, q_rdata;
	qstat_t qstat;
	logic   push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ORIGIN_X: ray_q.ox <= cfg.data;
				REG_ORIGIN_Y: ray_q.oy <= cfg.data;
				REG_ORIGIN_Z: ray_q.oz <= cfg.data;
				REG_DIR_X:    ray_q.dx <= cfg.data;
				REG_DIR_Y:    ray_q.dy <= cfg.data;
				REG_DIR_Z:    ray_q.dz <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	rti_front u_front (
		.triangle (triangle),
		.ray      (ray_q),
		.qstat    (qstat),
		.push     (push),
		.edges    (q_wdata)
	);

	rti_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.qstat  (qstat)
	);

	rti_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ray    (ray_q),
		.edges  (q_rdata),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hit |-> result.distance == '0)
		else $error("miss with nonzero distance");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue popped while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> qstat.count == (QAW+1)'($past(qstat.count) + 1'b1))
		else $error("queue count lost a beat");
`endif

endmodule

FILE: sim/ray_triangle_intersect_test.sv
// Testbench of the ray/triangle intersection block: streams triangles and checks every result.
`timescale 1ns / 100ps

module ray_triangle_intersect_test;
	import rti_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic              hit;
		logic [DIST_W-1:0] distance;
	} outcome_t;

	class hit_board;
		ray_t     ray;
		outcome_t awaited[$];

		function void note(tri_t t);
			wide_t ax = wide_t'(t.va_x), ay = wide_t'(t.va_y), az = wide_t'(t.va_z);
			wide_t rx = wide_t'(ray.dx), ry = wide_t'(ray.dy), rz = wide_t'(ray.dz);
			wide_t e1x = ax - wide_t'(t.vb_x), e1y = ay - wide_t'(t.vb_y);
			wide_t e1z = az - wide_t'(t.vb_z);
			wide_t e2x = ax - wide_t'(t.vc_x), e2y = ay - wide_t'(t.vc_y);
			wide_t e2z = az - wide_t'(t.vc_z);
			wide_t sx = ax - wide_t'(ray.ox), sy = ay - wide_t'(ray.oy);
			wide_t sz = az - wide_t'(ray.oz);
			wide_t m0 = e2y * rz - ry * e2z, m1 = rx * e2z - e2x * rz;
			wide_t m2 = e2x * ry - e2y * rx;
			wide_t n0 = e1x * sy - sx * e1y, n1 = sx * e1z - e1x * sz;
			wide_t n2 = e1y * sz - sy * e1z;
			wide_t det = e1x * m0 + e1y * m1 + e1z * m2;
			wide_t nt = -(e2z * n0 + e2y * n1 + e2x * n2);
			wide_t ng = rz * n0 + ry * n1 + rx * n2;
			wide_t nb = sx * m0 + sy * m1 + sz * m2;
			logic [127:0] quo;
			outcome_t o;
			o.hit = 1'b0;
			o.distance = '0;
			if (det != 0) begin
				if (det < 0) begin
					det = -det;
					nt = -nt;
					ng = -ng;
					nb = -nb;
				end
				o.hit = nt >= 0 && ng >= 0 && det - ng >= 0 && nb >= 0 && det - nb - ng >= 0;
			end
			if (o.hit) begin
				quo = $unsigned(nt <<< FRAC_BITS) / $unsigned(det);
				o.distance = (quo > 128'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];
			end
			awaited.push_back(o);
		endfunction

		function bit check(logic hit, logic [DIST_W-1:0] distance, output string msg);
			outcome_t o;
			if (awaited.size() == 0) begin
				msg = $sformatf("unexpected result beat hit=%0b distance=%0h", hit, distance);
				return 1'b0;
			end
			o = awaited.pop_front();
			if (hit !== o.hit || distance !== o.distance) begin
				msg = $sformatf("hit=%0b distance=%0h, wanted hit=%0b distance=%0h",
					hit, distance, o.hit, o.distance);
				return 1'b0;
			end
			return 1'b1;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   errors;
	bit   idle_on;
	bit   hold_req;
	hit_board board;

	rti_cfg_if cfg_ch();
	rti_tri_if tri_ch();
	rti_res_if res_ch();

	ray_triangle_intersect u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.triangle(tri_ch),
		.result(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	task report(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	always @(posedge clk) begin
		string msg;
		if (arst_n && res_ch.valid && res_ch.ready)
			if (!board.check(res_ch.hit, res_ch.distance, msg))
				report(msg);
	end

	// result side: random back-pressure, plus one long hold when asked
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task send_tri(tri_t t);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			tri_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		tri_ch.valid <= 1'b1;
		{tri_ch.va_x, tri_ch.va_y, tri_ch.va_z} <= {t.va_x, t.va_y, t.va_z};
		{tri_ch.vb_x, tri_ch.vb_y, tri_ch.vb_z} <= {t.vb_x, t.vb_y, t.vb_z};
		{tri_ch.vc_x, tri_ch.vc_y, tri_ch.vc_z} <= {t.vc_x, t.vc_y, t.vc_z};
		do @(posedge clk); while (!tri_ch.ready);
		board.note(t);
	endtask

	task drain;
		tri_ch.valid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task write_reg(cfg_reg_t idx, logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task set_ray(ray_t r);
		drain();
		write_reg(REG_ORIGIN_X, r.ox);
		write_reg(REG_ORIGIN_Y, r.oy);
		write_reg(REG_ORIGIN_Z, r.oz);
		write_reg(REG_DIR_X, r.dx);
		write_reg(REG_DIR_Y, r.dy);
		write_reg(REG_DIR_Z, r.dz);
		cfg_ch.valid <= 1'b0;
		board.ray = r;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] small_q(int lim);
		return ($urandom_range(0, 2 * lim) - lim) * 65536 + $urandom_range(0, 65535);
	endfunction

	function automatic ray_t near_ray();
		ray_t r;
		r.ox = small_q(100);
		r.oy = small_q(100);
		r.oz = small_q(100);
		r.dx = small_q(8);
		r.dy = small_q(8);
		r.dz = small_q(8);
		return r;
	endfunction

	function automatic tri_t noise_tri();
		tri_t t;
		t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		return t;
	endfunction

	// triangle placed around a point on the ray, so a good share are hits
	function automatic tri_t aimed_tri(ray_t r);
		tri_t t;
		int k;
		logic signed [31:0] px, py, pz;
		k = $urandom_range(0, 25) - 5;
		px = r.ox + k * r.dx;
		py = r.oy + k * r.dy;
		pz = r.oz + k * r.dz;
		t.va_x = px - $urandom_range(0, 5 << 16);
		t.va_y = py - $urandom_range(0, 5 << 16);
		t.va_z = pz + small_q(3);
		t.vb_x = px + $urandom_range(0, 5 << 16);
		t.vb_y = py - $urandom_range(0, 5 << 16);
		t.vb_z = pz + small_q(3);
		t.vc_x = px + small_q(2);
		t.vc_y = py + $urandom_range(0, 5 << 16);
		t.vc_z = pz + small_q(3);
		if ($urandom_range(0, 7) == 0) t.vc_x = t.va_x + t.vb_x - px;
		return t;
	endfunction

	function automatic tri_t mk(int ax, int ay, int az, int bx, int by, int bz,
		int cx, int cy, int cz);
		tri_t t;
		t = {ax, ay, az, bx, by, bz, cx, cy, cz};
		return t;
	endfunction

	localparam int ONE = 65536;
	localparam int MAXV = 32'h7fffffff;
	localparam int MINV = 32'h80000000;

	initial begin
		ray_t r;
		tri_t t;
		board = new();
		board.ray = '0;
		errors = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ORIGIN_X;
		cfg_ch.data = '0;
		tri_ch.valid = 1'b0;
		{tri_ch.va_x, tri_ch.va_y, tri_ch.va_z} = '0;
		{tri_ch.vb_x, tri_ch.vb_y, tri_ch.vb_z} = '0;
		{tri_ch.vc_x, tri_ch.vc_y, tri_ch.vc_z} = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ray has zero direction: all misses
		repeat (10) send_tri(noise_tri());
		send_tri(mk(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0));

		r = '{ox: 0, oy: 0, oz: 0, dx: 0, dy: 0, dz: ONE};
		set_ray(r);
		send_tri(mk(-ONE, -ONE, 5 * ONE, ONE, -ONE, 5 * ONE, 0, ONE, 5 * ONE));
		send_tri(mk(-ONE, -ONE, -5 * ONE, ONE, -ONE, -5 * ONE, 0, ONE, -5 * ONE));
		send_tri(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
		send_tri(mk(0, 0, 3 * ONE, ONE, 0, 3 * ONE, 0, ONE, 3 * ONE));
		send_tri(mk(ONE, 0, 2 * ONE, 0, 0, 2 * ONE, 0, ONE, 2 * ONE));
		send_tri(mk(ONE, 0, 2 * ONE, 0, ONE, 2 * ONE, -ONE, -ONE, 2 * ONE));
		send_tri(mk(0, -ONE, 2 * ONE, 0, ONE, 2 * ONE, -ONE, 0, 2 * ONE));
		send_tri(mk(-ONE, 0, ONE, ONE, 0, 2 * ONE, 3 * ONE, 0, 3 * ONE));
		send_tri(mk(0, 0, 0, ONE, 0, ONE, 2 * ONE, 0, 2 * ONE));
		send_tri(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tri(mk(2 * ONE, 2 * ONE, ONE, 3 * ONE, 2 * ONE, ONE, 2 * ONE, 3 * ONE, ONE));
		send_tri(mk(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV));
		send_tri(mk(MINV, MINV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV));
		send_tri(mk(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1));
		r = '{ox: 0, oy: 0, oz: 0, dx: 0, dy: 0, dz: 1};
		set_ray(r);
		send_tri(mk(-ONE, -ONE, 30000 * ONE, ONE, -ONE, 30000 * ONE, 0, ONE, 30000 * ONE));
		send_tri(mk(MINV, MINV, MAXV, MAXV, MINV, MAXV, 0, MAXV, MAXV));

		r = '{ox: MINV, oy: MINV, oz: MINV, dx: MAXV, dy: MAXV, dz: MAXV};
		set_ray(r);
		repeat (60) send_tri(noise_tri());
		repeat (20) send_tri(mk(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
		r = '{ox: MAXV, oy: MAXV, oz: MAXV, dx: MINV, dy: MINV, dz: MINV};
		set_ray(r);
		repeat (60) send_tri(noise_tri());
		repeat (20) send_tri(mk(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		set_ray(r);
		repeat (60) send_tri(noise_tri());

		for (int ph = 0; ph < 6; ph++) begin
			r = near_ray();
			set_ray(r);
			if (ph == 2) begin
				idle_on = 1'b0;
				hold_req = 1'b1;
			end
			if (ph == 5) idle_on = 1'b0;
			for (int n = 0; n < 170; n++) begin
				if ($urandom_range(0, 9) < 7) t = aimed_tri(r);
				else t = noise_tri();
				send_tri(t);
			end
			if (ph == 2) idle_on = 1'b1;
		end

		drain();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

FILE: filelist.f
src/rti_pkg.sv
src/rti_if.sv
src/rti_front.sv
src/rti_queue.sv
src/rti_div.sv
src/rti_back.sv
src/ray_triangle_intersect.sv
sim/ray_triangle_intersect_test.sv
